// ===== rtl/dqht_pkg.sv =====
package dqht_pkg;

	localparam int QUEUE_DEPTH  = 16;
	localparam int HANDLE_WIDTH = 32;

	localparam int ID_W    = 32;
	localparam int DATA_W  = 32;
	localparam int COUNT_W = 5;

	typedef enum logic [1:0] {
		REQ_PUSH_FRONT = 2'd0,
		REQ_PUSH_BACK  = 2'd1,
		REQ_POP_FRONT  = 2'd2,
		REQ_POP_BACK   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_FULL    = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	typedef struct packed {
		logic    wr_en;
		logic    rd_en;
		status_t status;
	} op_ctrl_t;

endpackage

// ===== rtl/dqht_ram.sv =====
module dqht_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/dqht_ctrl.sv =====
module dqht_ctrl #(
	parameter int QUEUE_DEPTH  = dqht_pkg::QUEUE_DEPTH,
	parameter int HANDLE_WIDTH = dqht_pkg::HANDLE_WIDTH,
	localparam int PW = $clog2(QUEUE_DEPTH),
	localparam int CW = $clog2(QUEUE_DEPTH + 1),
	localparam int SW = PW + 1,
	localparam int HW = (HANDLE_WIDTH < dqht_pkg::DATA_W) ? HANDLE_WIDTH : dqht_pkg::DATA_W
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic [1:0]                req_type,
	input  logic [dqht_pkg::DATA_W-1:0] entry_data,
	output dqht_pkg::op_ctrl_t        op,
	output logic [PW-1:0]             slot,
	output logic [CW-1:0]             count_next
);

	logic [PW-1:0] front_q;
	logic [CW-1:0] count_q;
	logic [PW-1:0] front_next;
	logic [PW-1:0] front_dec;
	logic [PW-1:0] front_inc;
	logic [SW-1:0] back_sum;
	logic [PW-1:0] back_slot;
	logic [PW-1:0] last_slot;
	logic          is_null;
	logic          is_full;
	logic          is_none;

	assign is_null = (entry_data[HW-1:0] == '0);
	assign is_full = (count_q == CW'(QUEUE_DEPTH));
	assign is_none = (count_q == '0);

	assign front_dec = (front_q == '0) ? PW'(QUEUE_DEPTH - 1) : front_q - 1'b1;
	assign front_inc = (front_q == PW'(QUEUE_DEPTH - 1)) ? '0 : front_q + 1'b1;

	// back slot is front + count, wrapped by one compare and subtract
	assign back_sum  = SW'(front_q) + SW'(count_q);
	assign back_slot = (back_sum >= SW'(QUEUE_DEPTH)) ?
		PW'(back_sum - SW'(QUEUE_DEPTH)) : PW'(back_sum);
	assign last_slot = (back_slot == '0) ? PW'(QUEUE_DEPTH - 1) : back_slot - 1'b1;

	always_comb begin
		op.wr_en   = 1'b0;
		op.rd_en   = 1'b0;
		op.status  = dqht_pkg::ST_OK;
		slot       = front_q;
		front_next = front_q;
		count_next = count_q;
		unique case (dqht_pkg::req_t'(req_type)) inside
			dqht_pkg::REQ_PUSH_FRONT, dqht_pkg::REQ_PUSH_BACK: begin
				if (is_null) begin
					op.status = dqht_pkg::ST_INVALID;
				end else if (is_full) begin
					op.status = dqht_pkg::ST_FULL;
				end else begin
					op.wr_en   = 1'b1;
					count_next = count_q + 1'b1;
					if (dqht_pkg::req_t'(req_type) == dqht_pkg::REQ_PUSH_FRONT) begin
						slot       = front_dec;
						front_next = front_dec;
					end else begin
						slot = back_slot;
					end
				end
			end
			dqht_pkg::REQ_POP_FRONT, dqht_pkg::REQ_POP_BACK: begin
				if (is_none) begin
					op.status = dqht_pkg::ST_EMPTY;
				end else begin
					op.rd_en   = 1'b1;
					count_next = count_q - 1'b1;
					if (dqht_pkg::req_t'(req_type) == dqht_pkg::REQ_POP_FRONT) begin
						slot       = front_q;
						front_next = front_inc;
					end else begin
						slot = last_slot;
					end
				end
			end
			default: begin
				op.status = dqht_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			front_q <= front_next;
			count_q <= count_next;
		end
	end

endmodule

// ===== rtl/deque_head_tail_ops_core.sv =====
// Bounded double-ended queue of (id, data handle) entries kept as a ring.
// Input channel (in_valid/in_ready) carries one request per beat:
// req_type selects push front, push back, pop front or pop back.
// Output channel (out_valid/out_ready) returns one result beat per
// request: status, popped entry (zero unless a pop succeeded), count
// held afterwards and an empty flag.
// Results are registered: a request accepted at a clock edge gives its
// result in the cycle after. Throughput is one request per cycle while
// out_ready keeps up; front pointer and count update in the accepting
// cycle, and the entry stores are simple dual port RAMs (one write and
// one read port) with a registered read that lands in the result stage.
// A null data handle is rejected before the full check.
// At reset the queue is empty and the front pointer is zero; slot
// contents are not cleared, only slots written by pushes are ever read.
// When the receiver stalls the result is held and in_ready drops until
// the result beat is taken.
module deque_head_tail_ops_core #(
	parameter int QUEUE_DEPTH  = dqht_pkg::QUEUE_DEPTH,
	parameter int HANDLE_WIDTH = dqht_pkg::HANDLE_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   req_type,
	input  logic [dqht_pkg::ID_W-1:0]    entry_id,
	input  logic [dqht_pkg::DATA_W-1:0]  entry_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   status,
	output logic [dqht_pkg::ID_W-1:0]    popped_id,
	output logic [dqht_pkg::DATA_W-1:0]  popped_data,
	output logic [dqht_pkg::COUNT_W-1:0] entry_count,
	output logic                         is_empty
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int HW = (HANDLE_WIDTH < dqht_pkg::DATA_W) ? HANDLE_WIDTH : dqht_pkg::DATA_W;

	dqht_pkg::op_ctrl_t op;
	logic [PW-1:0]      slot;
	logic [CW-1:0]      count_next;
	logic               accept;
	logic               out_valid_q;
	dqht_pkg::status_t  status_s1;
	logic [CW-1:0]      count_s1;
	logic               pop_s1;
	logic [dqht_pkg::ID_W-1:0] rd_id;
	logic [HW-1:0]      rd_data;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	dqht_ctrl #(
		.QUEUE_DEPTH  (QUEUE_DEPTH),
		.HANDLE_WIDTH (HANDLE_WIDTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.req_type   (req_type),
		.entry_data (entry_data),
		.op         (op),
		.slot       (slot),
		.count_next (count_next)
	);

	dqht_ram #(
		.WIDTH (dqht_pkg::ID_W),
		.DEPTH (QUEUE_DEPTH)
	) u_id_ram (
		.clk   (clk),
		.we    (accept && op.wr_en),
		.waddr (slot),
		.wdata (entry_id),
		.re    (accept && op.rd_en),
		.raddr (slot),
		.rdata (rd_id)
	);

	dqht_ram #(
		.WIDTH (HW),
		.DEPTH (QUEUE_DEPTH)
	) u_data_ram (
		.clk   (clk),
		.we    (accept && op.wr_en),
		.waddr (slot),
		.wdata (entry_data[HW-1:0]),
		.re    (accept && op.rd_en),
		.raddr (slot),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= op.status;
			count_s1  <= count_next;
			pop_s1    <= op.rd_en;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_s1;
	assign popped_id   = {dqht_pkg::ID_W{pop_s1}} & rd_id;
	assign popped_data = {dqht_pkg::DATA_W{pop_s1}} & dqht_pkg::DATA_W'(rd_data);
	assign entry_count = dqht_pkg::COUNT_W'(count_s1);
	assign is_empty    = (count_s1 == '0);

endmodule
